// ===== hw/rtl/htrc_pkg.sv =====
package htrc_pkg;

  localparam int unsigned HEIGHT_W        = 32;
  localparam int unsigned COLUMN_W        = 12;
  localparam int unsigned LEVEL_W         = 32;
  localparam int unsigned COLOUR_W        = 8;
  localparam int unsigned SLOPE_FRAC_BITS = 16;
  localparam int unsigned CFG_INDEX_W     = 3;

  // Divider operands: the distance never exceeds the span, so both fit 32 bits
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_REM_W = DIV_W + COLOUR_W;

  localparam logic [COLOUR_W-1:0] COLOUR_FULL = '1;
  localparam logic [COLOUR_W-1:0] COLOUR_NONE = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VIOLET     = 3'd0,
    REG_BLUE       = 3'd1,
    REG_LIGHT_BLUE = 3'd2,
    REG_GREEN      = 3'd3,
    REG_YELLOW     = 3'd4,
    REG_RED        = 3'd5,
    REG_TILT_SLOPE = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } channel_t;

  typedef struct packed {
    logic                       op;
    logic signed [HEIGHT_W-1:0] height;
    logic [COLUMN_W-1:0]        column;
    logic                       restart;
  } in_beat_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red_out;
    logic [COLOUR_W-1:0] green_out;
    logic [COLOUR_W-1:0] blue_out;
  } out_beat_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] violet_level;
    logic signed [LEVEL_W-1:0] blue_level;
    logic signed [LEVEL_W-1:0] light_blue_level;
    logic signed [LEVEL_W-1:0] green_level;
    logic signed [LEVEL_W-1:0] yellow_level;
    logic signed [LEVEL_W-1:0] red_level;
    logic signed [LEVEL_W-1:0] tilt_slope;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [COLOUR_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hw/rtl/height_tilt_rainbow_colormap.sv =====
// Rainbow colouring of a height image in two passes. Scan beats (op 0) keep the
// block idle and update the running minimum height (restart seeds it afresh).
// Colour beats (op 1) remove the column tilt, apply the minimum floor and map
// the height through the six levels to red, green and blue. A colour beat holds
// in_ready low while it steps through the tilt, subtract, correct and compare
// states, then a prepare state for each channel in turn; each channel that lands
// on a ramp also runs on the one shared restoring divider (eight quotient bits,
// one per cycle), and at most two channels of a beat land on a ramp. The result
// is then handed to an output register, so the next beat is taken while it waits
// for out_ready; a finished beat whose result finds that register still full
// holds in_ready low until out_ready frees it. The user must write levels and
// slope only while idle; the block itself does not enforce this.
module height_tilt_rainbow_colormap #(
  parameter int MAX_COLUMNS      = 4096,
  parameter int HEIGHT_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  htrc_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output htrc_pkg::out_beat_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [htrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [htrc_pkg::LEVEL_W-1:0]     cfg_data
);

  localparam int unsigned HW     = htrc_pkg::HEIGHT_W;
  localparam int unsigned CW     = htrc_pkg::COLUMN_W;
  localparam int unsigned PW     = htrc_pkg::LEVEL_W + CW + 1;
  localparam int unsigned XW     = PW + 1;
  localparam int unsigned SHIFT  = htrc_pkg::SLOPE_FRAC_BITS - HEIGHT_FRAC_BITS;
  localparam int unsigned MAXC_W = 17;

  localparam longint MIN_RAW = longint'(1000000) <<< HEIGHT_FRAC_BITS;
  localparam longint MIN_SAT = (MIN_RAW > 64'sd2147483647) ? 64'sd2147483647 : MIN_RAW;
  localparam logic signed [HW-1:0] MIN_RESET = HW'(MIN_SAT);

  localparam logic [MAXC_W-1:0] MAXC     = MAXC_W'(MAX_COLUMNS);
  localparam logic [CW-1:0]     COL_LAST = CW'(MAX_COLUMNS - 1);
  localparam logic signed [XW-1:0] ONE_H = XW'(64'd1 << HEIGHT_FRAC_BITS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TILT = 7'b0000010,
    S_SUB  = 7'b0000100,
    S_CORR = 7'b0001000,
    S_CMP  = 7'b0010000,
    S_PREP = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic le_vi;
    logic lt_bl;
    logic lt_lb;
    logic lt_gr;
    logic lt_ye;
    logic lt_rd;
  } flags_t;

  state_t                               state;
  htrc_pkg::channel_t                   ch;
  htrc_pkg::cfg_t                       cfg;
  htrc_pkg::div_req_t                   div_req;
  htrc_pkg::div_rsp_t                   div_rsp;
  flags_t                               flags;
  logic signed [HW-1:0]                 min_height;
  logic signed [HW-1:0]                 h_in;
  logic [CW-1:0]                        col_q;
  logic signed [PW-1:0]                 prod;
  logic signed [XW-1:0]                 h_sub;
  logic signed [XW-1:0]                 h_cor;
  logic [htrc_pkg::COLOUR_W-1:0]        colour [3];
  logic [htrc_pkg::DIV_W-1:0]           num_q;
  logic [htrc_pkg::DIV_W-1:0]           den_q;
  logic                                 div_go;
  logic                                 done_hold;
  logic                                 in_fire;
  logic                                 out_load;
  logic                                 last_ch;
  logic [CW-1:0]                        col_c;
  logic signed [XW-1:0]                 min_x;
  logic signed [XW-1:0]                 vi_x, bl_x, lb_x, gr_x, ye_x, rd_x;
  logic                                 is_ramp;
  logic [htrc_pkg::COLOUR_W-1:0]        flat_val;
  logic signed [XW-1:0]                 na, nb, da, db;
  logic signed [XW-1:0]                 num_w, den_w;

  htrc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  htrc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE) && !done_hold;
  assign in_fire  = in_valid && in_ready;
  assign out_load = done_hold && (!out_valid || out_ready);
  assign last_ch  = (ch == htrc_pkg::CH_BLUE);

  assign col_c = ({{(MAXC_W-CW){1'b0}}, in_data.column} >= MAXC) ? COL_LAST : in_data.column;

  assign min_x = XW'(min_height);
  assign vi_x  = XW'(cfg.violet_level);
  assign bl_x  = XW'(cfg.blue_level);
  assign lb_x  = XW'(cfg.light_blue_level);
  assign gr_x  = XW'(cfg.green_level);
  assign ye_x  = XW'(cfg.yellow_level);
  assign rd_x  = XW'(cfg.red_level);

  // Pick the ramp operands for the current channel: distance na - nb, span da - db
  always_comb begin
    is_ramp  = 1'b0;
    flat_val = htrc_pkg::COLOUR_NONE;
    na = h_cor;
    nb = h_cor;
    da = h_cor;
    db = h_cor;
    case (ch)
      htrc_pkg::CH_RED: begin
        if (flags.le_vi) begin
          flat_val = htrc_pkg::COLOUR_FULL;
        end else if (flags.lt_bl) begin
          is_ramp = 1'b1;
          na = bl_x; nb = h_cor; da = bl_x; db = vi_x;
        end else if (flags.lt_gr) begin
          flat_val = htrc_pkg::COLOUR_NONE;
        end else if (flags.lt_ye) begin
          is_ramp = 1'b1;
          na = h_cor; nb = gr_x; da = ye_x; db = gr_x;
        end else begin
          flat_val = htrc_pkg::COLOUR_FULL;
        end
      end
      htrc_pkg::CH_GREEN: begin
        if (flags.lt_bl) begin
          flat_val = htrc_pkg::COLOUR_NONE;
        end else if (flags.lt_lb) begin
          is_ramp = 1'b1;
          na = h_cor; nb = bl_x; da = lb_x; db = bl_x;
        end else if (flags.lt_ye) begin
          flat_val = htrc_pkg::COLOUR_FULL;
        end else if (flags.lt_rd) begin
          is_ramp = 1'b1;
          na = rd_x; nb = h_cor; da = rd_x; db = ye_x;
        end else begin
          flat_val = htrc_pkg::COLOUR_NONE;
        end
      end
      htrc_pkg::CH_BLUE: begin
        if (flags.lt_lb) begin
          flat_val = htrc_pkg::COLOUR_FULL;
        end else if (flags.lt_gr) begin
          is_ramp = 1'b1;
          na = gr_x; nb = h_cor; da = gr_x; db = lb_x;
        end else begin
          flat_val = htrc_pkg::COLOUR_NONE;
        end
      end
      default: begin
        flat_val = htrc_pkg::COLOUR_NONE;
      end
    endcase
    num_w = na - nb;
    den_w = da - db;
  end

  assign div_req.start = div_go;
  assign div_req.num   = num_q;
  assign div_req.den   = den_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ch         <= htrc_pkg::CH_RED;
      min_height <= MIN_RESET;
      div_go     <= 1'b0;
      done_hold  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
        done_hold <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.op) begin
              state <= S_TILT;
            end else if (in_data.restart || (in_data.height < min_height)) begin
              min_height <= in_data.height;
            end
          end
        end
        S_TILT: state <= S_SUB;
        S_SUB:  state <= S_CORR;
        S_CORR: state <= S_CMP;
        S_CMP: begin
          ch    <= htrc_pkg::CH_RED;
          state <= S_PREP;
        end
        S_PREP: begin
          if (is_ramp) begin
            div_go <= 1'b1;
            state  <= S_DIV;
          end else if (last_ch) begin
            done_hold <= 1'b1;
            state     <= S_IDLE;
          end else begin
            ch <= htrc_pkg::channel_t'(ch + 1'b1);
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (last_ch) begin
              done_hold <= 1'b1;
              state     <= S_IDLE;
            end else begin
              ch    <= htrc_pkg::channel_t'(ch + 1'b1);
              state <= S_PREP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      h_in  <= in_data.height;
      col_q <= col_c;
    end
    if (state == S_TILT) begin
      prod <= cfg.tilt_slope * $signed({1'b0, col_q});
    end
    if (state == S_SUB) begin
      h_sub <= XW'(h_in) - XW'(prod >>> SHIFT);
    end
    if (state == S_CORR) begin
      if (h_in == min_height) begin
        h_cor <= XW'(h_in);
      end else if (h_sub < min_x) begin
        h_cor <= min_x + ONE_H;
      end else begin
        h_cor <= h_sub;
      end
    end
    if (state == S_CMP) begin
      flags.le_vi <= (h_cor <= vi_x);
      flags.lt_bl <= (h_cor < bl_x);
      flags.lt_lb <= (h_cor < lb_x);
      flags.lt_gr <= (h_cor < gr_x);
      flags.lt_ye <= (h_cor < ye_x);
      flags.lt_rd <= (h_cor < rd_x);
    end
    if (state == S_PREP) begin
      num_q <= num_w[htrc_pkg::DIV_W-1:0];
      den_q <= den_w[htrc_pkg::DIV_W-1:0];
      if (!is_ramp) begin
        colour[ch] <= flat_val;
      end
    end
    if ((state == S_DIV) && div_rsp.done) begin
      colour[ch] <= div_rsp.quo;
    end
    if (out_load) begin
      out_data.red_out   <= colour[htrc_pkg::CH_RED];
      out_data.green_out <= colour[htrc_pkg::CH_GREEN];
      out_data.blue_out  <= colour[htrc_pkg::CH_BLUE];
    end
  end

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  a_scan_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_data.op) |=> (state == S_IDLE))
    else $error("scan beat started a colour sequence");

  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done_hold))
    else $error("result presented without a finished colour beat");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    (ch == htrc_pkg::CH_RED) || (ch == htrc_pkg::CH_GREEN) || (ch == htrc_pkg::CH_BLUE))
    else $error("channel counter out of range");

endmodule

// ===== hw/rtl/htrc_cfg_regs.sv =====
module htrc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [htrc_pkg::CFG_INDEX_W-1:0]    index,
  input  logic [htrc_pkg::LEVEL_W-1:0]        data,
  output htrc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (index)
        htrc_pkg::REG_VIOLET:     cfg.violet_level     <= data;
        htrc_pkg::REG_BLUE:       cfg.blue_level       <= data;
        htrc_pkg::REG_LIGHT_BLUE: cfg.light_blue_level <= data;
        htrc_pkg::REG_GREEN:      cfg.green_level      <= data;
        htrc_pkg::REG_YELLOW:     cfg.yellow_level     <= data;
        htrc_pkg::REG_RED:        cfg.red_level        <= data;
        htrc_pkg::REG_TILT_SLOPE: cfg.tilt_slope       <= data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

endmodule

// ===== hw/rtl/htrc_div.sv =====
module htrc_div (
  input  logic               clk,
  input  logic               rst,
  input  htrc_pkg::div_req_t req,
  output htrc_pkg::div_rsp_t rsp
);

  localparam int unsigned QW  = htrc_pkg::COLOUR_W;
  localparam int unsigned RW  = htrc_pkg::DIV_REM_W;
  localparam int unsigned CNW = $clog2(QW);

  logic [RW-1:0]  rem;
  logic [RW-1:0]  dsh;
  logic [QW-1:0]  quo;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic           done;
  logic           fits;
  logic [RW-1:0]  num_x;

  // 255 * num as a shift and subtract
  assign num_x = (RW'(req.num) << QW) - RW'(req.num);
  assign fits  = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNW'(QW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One quotient bit a cycle, divisor walking down from its top alignment
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= num_x;
      dsh <= RW'(req.den) << (QW - 1);
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[QW-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
